// File: hdl/assert_macros.svh
// Assertion macros shared by the MD5 controller and datapath.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/md5_pkg.sv
// Package for the MD5 digest engine: state and command types, round constants,
// and the round helper functions. No dependencies.
`default_nettype none

package md5_pkg;

  typedef logic [3:0][31:0] word4_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD80,
    ST_PADZ,
    ST_LEN,
    ST_INIT,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SEL_IN,
    SEL_PAD80,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      wr_en;
    byte_sel_t byte_sel;
    logic      len_add;
    logic      comp_init;
    logic      round_en;
    logic      chain_add;
    logic      emit_adv;
    logic      clear;
  } cmd_t;

  typedef struct packed {
    logic pos_is63;
    logic pos_is56;
    logic round_last;
    logic idx_last;
  } sts_t;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] POS_LAST  = 6'd63;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [1:0] IDX_LAST  = 2'd3;

  localparam word4_t CHAIN_INIT = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] SHIFT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] q;
    q = r[3:0];
    case (r[5:4])
      2'd0:    msg_index = q;
      2'd1:    msg_index = q * 4'd5 + 4'd1;
      2'd2:    msg_index = q * 4'd3 + 4'd5;
      default: msg_index = q * 4'd7;
    endcase
  endfunction

  function automatic logic [31:0] round_fn(input logic [1:0] grp, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    case (grp)
      2'd0:    round_fn = (b & c) | (~b & d);
      2'd1:    round_fn = (b & d) | (c & ~d);
      2'd2:    round_fn = b ^ c ^ d;
      default: round_fn = c ^ (b | ~d);
    endcase
  endfunction

  function automatic logic [31:0] rot_left(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    rot_left = w[63:32];
  endfunction

endpackage

`default_nettype wire

// File: hdl/md5_if.sv
// Stream interfaces of the MD5 digest engine: message byte channel and digest channel.
// Standalone; payload widths are fixed by the field definitions.
`default_nettype none

interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, data_byte, has_byte, last, input ready);
  modport sink (input valid, data_byte, has_byte, last, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

// File: hdl/md5_ctrl.sv
// Controller of the MD5 digest engine: sequences byte loading, padding, rounds and
// digest output. Depends on md5_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module md5_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_has_byte,
  input  wire logic          in_last,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output md5_pkg::cmd_t      cmd,
  input  wire md5_pkg::sts_t sts
);
  import md5_pkg::*;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    cmd          = '0;
    cmd.byte_sel = SEL_IN;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_has_byte) begin
            cmd.wr_en   = 1'b1;
            cmd.len_add = 1'b1;
            if (sts.pos_is63) begin
              state_nxt = ST_INIT;
              ret_nxt   = in_last ? ST_PAD80 : ST_IDLE;
            end else if (in_last) begin
              state_nxt = ST_PAD80;
            end
          end else if (in_last) begin
            state_nxt = ST_PAD80;
          end
        end
      end
      ST_PAD80: begin
        cmd.wr_en    = 1'b1;
        cmd.byte_sel = SEL_PAD80;
        state_nxt    = ST_PADZ;
        if (sts.pos_is63) begin
          state_nxt = ST_INIT;
          ret_nxt   = ST_PADZ;
        end
      end
      ST_PADZ: begin
        if (sts.pos_is56) begin
          state_nxt = ST_LEN;
        end else begin
          cmd.wr_en    = 1'b1;
          cmd.byte_sel = SEL_ZERO;
          if (sts.pos_is63) begin
            state_nxt = ST_INIT;
            ret_nxt   = ST_PADZ;
          end
        end
      end
      ST_LEN: begin
        cmd.wr_en    = 1'b1;
        cmd.byte_sel = SEL_LEN;
        if (sts.pos_is63) begin
          state_nxt = ST_INIT;
          ret_nxt   = ST_EMIT;
        end
      end
      ST_INIT: begin
        cmd.comp_init = 1'b1;
        state_nxt     = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        if (sts.round_last) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.chain_add = 1'b1;
        state_nxt     = ret_r;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_adv = 1'b1;
          if (sts.idx_last) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
            ret_nxt   = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        ret_nxt   = ST_IDLE;
      end
    endcase
  end

  `ASSERT_NEXT(a_round_to_add, clk, rst_n, state_r == ST_ROUND && sts.round_last, state_r == ST_ADD, "last round did not lead to the chain add")
  `ASSERT_NEXT(a_emit_done_idle, clk, rst_n, out_valid && out_ready && sts.idx_last, state_r == ST_IDLE && in_ready, "engine not idle after the final digest beat")

endmodule

`default_nettype wire

// File: hdl/md5_dp.sv
// Datapath of the MD5 digest engine: block buffer, length and position counters,
// round engine and chaining words. Depends on md5_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module md5_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire md5_pkg::cmd_t cmd,
  output md5_pkg::sts_t      sts,
  input  wire logic [7:0]    in_data_byte,
  output logic [31:0]        out_digest_word,
  output logic [1:0]         out_word_index,
  output logic               out_last_word
);
  import md5_pkg::*;

  logic [31:0] block_r [16];
  word4_t      chain_r, chain_nxt;
  word4_t      rw_r;
  logic [31:0] km_r;
  logic [63:0] len_r, len_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [5:0]  rcnt_r, rcnt_nxt;
  logic [1:0]  idx_r, idx_nxt;

  logic [7:0]  wr_byte;
  logic [5:0]  r_next;
  logic [31:0] f_val;
  logic [31:0] sum_val;
  logic [31:0] t_val;

  always_comb begin
    case (cmd.byte_sel)
      SEL_IN:    wr_byte = in_data_byte;
      SEL_PAD80: wr_byte = PAD_BYTE;
      SEL_ZERO:  wr_byte = 8'h00;
      SEL_LEN:   wr_byte = len_r[{pos_r[2:0], 3'b000} +: 8];
      default:   wr_byte = 8'h00;
    endcase
  end

  assign r_next  = cmd.comp_init ? 6'd0 : rcnt_r + 6'd1;
  assign f_val   = round_fn(rcnt_r[5:4], rw_r[1], rw_r[2], rw_r[3]);
  assign sum_val = rw_r[0] + f_val + km_r;
  assign t_val   = rw_r[1] + rot_left(sum_val, SHIFT_AMT[{rcnt_r[5:4], rcnt_r[1:0]}]);

  always_comb begin
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    rcnt_nxt  = rcnt_r;
    idx_nxt   = idx_r;
    chain_nxt = chain_r;
    if (cmd.wr_en) begin
      pos_nxt = pos_r + 6'd1;
    end
    if (cmd.len_add) begin
      len_nxt = len_r + 64'd8;
    end
    if (cmd.comp_init || cmd.round_en) begin
      rcnt_nxt = r_next;
    end
    if (cmd.chain_add) begin
      for (int i = 0; i < 4; i++) begin
        chain_nxt[i] = chain_r[i] + rw_r[i];
      end
      rcnt_nxt = '0;
    end
    if (cmd.emit_adv) begin
      idx_nxt = idx_r + 2'd1;
    end
    if (cmd.clear) begin
      pos_nxt   = '0;
      len_nxt   = '0;
      rcnt_nxt  = '0;
      idx_nxt   = '0;
      chain_nxt = CHAIN_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      len_r   <= '0;
      rcnt_r  <= '0;
      idx_r   <= '0;
      chain_r <= CHAIN_INIT;
    end else begin
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      rcnt_r  <= rcnt_nxt;
      idx_r   <= idx_nxt;
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      if (pos_r[1:0] == 2'd0) begin
        block_r[pos_r[5:2]] <= {24'h000000, wr_byte};
      end else begin
        block_r[pos_r[5:2]][{pos_r[1:0], 3'b000} +: 8] <= wr_byte;
      end
    end
  end

  // The constant and message word of the coming round are summed ahead of it and registered in km_r.
  always_ff @(posedge clk) begin
    if (cmd.comp_init || cmd.round_en) begin
      km_r <= SINE_K[r_next] + block_r[msg_index(r_next)];
    end
    if (cmd.comp_init) begin
      rw_r <= chain_r;
    end else if (cmd.round_en) begin
      rw_r[0] <= rw_r[3];
      rw_r[1] <= t_val;
      rw_r[2] <= rw_r[1];
      rw_r[3] <= rw_r[2];
    end
  end

  assign sts.pos_is63   = (pos_r == POS_LAST);
  assign sts.pos_is56   = (pos_r == LEN_START);
  assign sts.round_last = (rcnt_r == ROUND_LAST);
  assign sts.idx_last   = (idx_r == IDX_LAST);

  assign out_digest_word = chain_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == IDX_LAST);

  `ASSERT_SAME(a_no_write_in_rounds, clk, rst_n, cmd.round_en || cmd.comp_init || cmd.chain_add, !cmd.wr_en, "block buffer written during compression")
  `ASSERT_NEXT(a_clear_state, clk, rst_n, cmd.clear, pos_r == 6'd0 && len_r == 64'd0 && chain_r == CHAIN_INIT, "message state not cleared after the digest")

endmodule

`default_nettype wire

// File: hdl/md5_message_digest_top.sv
// Top level of the MD5 digest engine: joins the controller and the datapath.
// Depends on md5_pkg, md5_if, md5_ctrl and md5_dp.
//
//   channel  dir  payload                                        beat when
//   in_ch    in   data_byte[7:0], has_byte, last                 valid && ready
//   out_ch   out  digest_word[31:0], word_index[1:0], last_word  valid && ready
//
// A byte beat writes one buffer byte; every 64th byte starts a compression
// (one load step, 64 rounds on a single round unit, one chain add). Closing
// writes the padding and length bytes with an idle step before the length, then
// runs one or two compressions and four digest beats.
// Reset is synchronous and active low; the input is not ready while a block
// compresses or while the digest is being delivered, and output stalls hold it.
`default_nettype none

module md5_message_digest_top (
  input wire logic  clk,
  input wire logic  rst_n,
  md5_in_if.sink    in_ch,
  md5_out_if.source out_ch
);
  import md5_pkg::*;

  cmd_t cmd;
  sts_t sts;

  md5_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_has_byte (in_ch.has_byte),
    .in_last     (in_ch.last),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  md5_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_data_byte    (in_ch.data_byte),
    .out_digest_word (out_ch.digest_word),
    .out_word_index  (out_ch.word_index),
    .out_last_word   (out_ch.last_word)
  );

endmodule

`default_nettype wire

// File: bench/md5_message_digest_top_tb.sv
// Self-checking bench for md5_message_digest_top: streams messages of random length, predicts
// each digest with an MD5 model kept in a scoreboard class, and checks every digest beat.
// Depends on md5_pkg, md5_if and the md5_message_digest_top RTL.
`timescale 1ns / 100ps

module md5_message_digest_top_tb;

  import md5_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  index;
    logic        is_last;
  } digest_beat_t;

  class digest_scoreboard;
    logic [31:0]  sine_k [64];
    int           rot_amt [16];
    logic [31:0]  chain [4];
    logic [31:0]  msg_block [16];
    logic [63:0]  msg_bits;
    int           fill;
    digest_beat_t digest_q [$];
    int           mismatches;

    function new();
      sine_k = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
      };
      rot_amt = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = 32'h67452301;
      chain[1] = 32'hefcdab89;
      chain[2] = 32'h98badcfe;
      chain[3] = 32'h10325476;
      msg_bits = '0;
      fill = 0;
    endfunction

    function void compress();
      logic [31:0] a, b, c, d, f, sum, t;
      int g;
      int s;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int r = 0; r < 64; r++) begin
        case (r / 16)
          0: begin
            f = (b & c) | (~b & d);
            g = r;
          end
          1: begin
            f = (d & b) | (~d & c);
            g = (5 * r + 1) % 16;
          end
          2: begin
            f = b ^ c ^ d;
            g = (3 * r + 5) % 16;
          end
          default: begin
            f = c ^ (b | ~d);
            g = (7 * r) % 16;
          end
        endcase
        sum = a + f + sine_k[r] + msg_block[g];
        s = rot_amt[(r / 16) * 4 + r % 4];
        t = b + ((sum << s) | (sum >> (32 - s)));
        a = d;
        d = c;
        c = b;
        b = t;
      end
      chain[0] = chain[0] + a;
      chain[1] = chain[1] + b;
      chain[2] = chain[2] + c;
      chain[3] = chain[3] + d;
    endfunction

    function void put_byte(logic [7:0] v);
      if (fill % 4 == 0) begin
        msg_block[fill / 4] = {24'h0, v};
      end else begin
        msg_block[fill / 4][(fill % 4) * 8 +: 8] = v;
      end
      fill++;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    endfunction

    function void note_input(logic [7:0] data, logic has_data, logic close);
      logic [63:0] saved_bits;
      digest_beat_t beat;
      if (has_data) begin
        put_byte(data);
        msg_bits = msg_bits + 64'd8;
      end
      if (!close) begin
        return;
      end
      saved_bits = msg_bits;
      put_byte(8'h80);
      while (fill != 56) begin
        put_byte(8'h00);
      end
      msg_block[14] = saved_bits[31:0];
      msg_block[15] = saved_bits[63:32];
      compress();
      for (int j = 0; j < 4; j++) begin
        beat.word = chain[j];
        beat.index = j[1:0];
        beat.is_last = (j == 3);
        digest_q.push_back(beat);
      end
      restart();
    endfunction

    function int pending();
      return digest_q.size();
    endfunction

    task report(string msg);
      $display("tb: mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic [31:0] word, logic [1:0] index, logic is_last);
      digest_beat_t want;
      if (digest_q.size() == 0) begin
        report($sformatf("digest beat %h/%0d with nothing expected", word, index));
        return;
      end
      want = digest_q.pop_front();
      if (word !== want.word) begin
        report($sformatf("digest_word %h, expected %h", word, want.word));
      end
      if (index !== want.index) begin
        report($sformatf("word_index %0d, expected %0d", index, want.index));
      end
      if (is_last !== want.is_last) begin
        report($sformatf("last_word %b, expected %b", is_last, want.is_last));
      end
    endtask

    task check_leftovers();
      if (digest_q.size() != 0) begin
        report($sformatf("%0d digest beats never arrived", digest_q.size()));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  md5_in_if  in_ch();
  md5_out_if out_ch();

  md5_message_digest_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  digest_scoreboard sb;
  int  send_idle_pct = 12;
  int  recv_idle_pct = 58;
  int  message_bytes = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;
  int  drain_guard;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.digest_word, out_ch.word_index, out_ch.last_word);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_item(input logic [7:0] d, input logic hb, input logic lc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.has_byte <= hb;
    in_ch.last <= lc;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    sb.note_input(d, hb, lc);
    if (hb) begin
      message_bytes++;
    end
  endtask

  task automatic send_message(input int len);
    bit close_with_byte;
    close_with_byte = (len > 0) && $urandom_range(1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(11) == 0) begin
        send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      end
      send_item(8'($urandom_range(255)), 1'b1, close_with_byte && (i == len - 1));
    end
    if (!close_with_byte) begin
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    end
  endtask

  function automatic int pick_length();
    int edge_lens [10];
    int pick;
    edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    pick = $urandom_range(99);
    if (pick < 45) begin
      return $urandom_range(12, 0);
    end else if (pick < 70) begin
      return $urandom_range(50, 13);
    end else if (pick < 90) begin
      return edge_lens[$urandom_range(9)];
    end
    return $urandom_range(140, 65);
  endfunction

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    sb = new();
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.has_byte <= 1'b0;
    in_ch.last <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(8'hA5, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b1);
    drain_results();

    hold_req = 1'b1;
    send_message(3);
    send_message(10);
    send_message(0);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      int phase_end;
      case (phase)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 58;
        end
        1: begin
          send_idle_pct = 58;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_end = message_bytes + 50;
      while (message_bytes < phase_end) begin
        send_message(pick_length());
      end
      drain_results();
    end

    in_ch.valid <= 1'b0;
    drain_guard = 0;
    while (sb.pending() != 0 && drain_guard < 50000) begin
      @(posedge clk);
      drain_guard++;
    end
    repeat (200) @(posedge clk);
    sb.check_leftovers();
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/md5_pkg.sv
hdl/md5_if.sv
hdl/md5_ctrl.sv
hdl/md5_dp.sv
hdl/md5_message_digest_top.sv
bench/md5_message_digest_top_tb.sv
